// ===== rtl/sbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrt_pkg
// shared types and constants of the split bus request table
// ----------------------------------------------------------------------------
package sbrt_pkg;

	localparam int CORE_W  = 4;
	localparam int KIND_W  = 3;
	localparam int ADDR_W  = 64;
	localparam int DELAY_W = 8;

	// op codes of a request
	localparam logic OP_SEND = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [DELAY_W-1:0] BUS_DELAY_RST = 8'd10;

	typedef struct packed {
		logic              op;
		logic [CORE_W-1:0] core;
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
	} sbrt_item_t;

	typedef struct packed {
		logic              accepted;
		logic              completed;
		logic [CORE_W-1:0] core;
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
	} sbrt_result_t;

endpackage

// ===== rtl/sbrt_table.sv =====
// ----------------------------------------------------------------------------
// sbrt_table
// slot table: allocation, aging pass and retirement in one pass per request
// ----------------------------------------------------------------------------
module sbrt_table #(
	parameter int TABLE_SLOTS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  sbrt_pkg::sbrt_item_t            item,
	input  logic [sbrt_pkg::DELAY_W-1:0]    bus_delay,
	output sbrt_pkg::sbrt_result_t          result
);
	import sbrt_pkg::*;

	logic [TABLE_SLOTS-1:0] pend_q;
	logic [DELAY_W-1:0]     age_q  [TABLE_SLOTS];
	logic [CORE_W-1:0]      core_q [TABLE_SLOTS];
	logic [KIND_W-1:0]      kind_q [TABLE_SLOTS];
	logic [ADDR_W-1:0]      addr_q [TABLE_SLOTS];

	logic                   do_alloc;
	logic [TABLE_SLOTS-1:0] free;
	logic [TABLE_SLOTS-1:0] alloc_oh;
	logic [TABLE_SLOTS-1:0] pend_a;
	logic [TABLE_SLOTS-1:0] expired;
	logic [TABLE_SLOTS-1:0] retire_oh;
	logic [TABLE_SLOTS-1:0] below;
	logic [TABLE_SLOTS-1:0] aging;
	logic [DELAY_W-1:0]     age_a [TABLE_SLOTS];

	always_comb begin
		free     = ~pend_q;
		do_alloc = (item.op == OP_SEND) && !(&pend_q);
		// lowest free slot
		alloc_oh = do_alloc ? (free & (~free + TABLE_SLOTS'(1))) : '0;
		pend_a   = pend_q | alloc_oh;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			age_a[i]   = alloc_oh[i] ? '0 : age_q[i];
			expired[i] = pend_a[i] && (age_a[i] >= bus_delay);
		end
		// first expired slot retires, the pass stops there
		retire_oh = expired & (~expired + TABLE_SLOTS'(1));
		below     = retire_oh - TABLE_SLOTS'(1);
		aging     = pend_a & ~expired & below;

		result           = '0;
		result.accepted  = do_alloc;
		result.completed = |retire_oh;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (retire_oh[i]) begin
				result.core    = alloc_oh[i] ? item.core    : core_q[i];
				result.kind    = alloc_oh[i] ? item.kind    : kind_q[i];
				result.address = alloc_oh[i] ? item.address : addr_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				age_q[i] <= '0;
			end
		end else if (fire) begin
			pend_q <= pend_a & ~retire_oh;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				age_q[i] <= aging[i] ? age_a[i] + DELAY_W'(1) : age_a[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (fire && alloc_oh[i]) begin
				core_q[i] <= item.core;
				kind_q[i] <= item.kind;
				addr_q[i] <= item.address;
			end
		end
	end

	// a send is refused only on a full table
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.op == OP_SEND) && !result.accepted |-> (&pend_q))
		else $error("send refused with a free slot");

	// pending population follows allocations and retirements
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> ($countones(pend_q) == $past($countones(pend_q))
			+ int'($past(result.accepted)) - int'($past(result.completed))))
		else $error("pending slot count mismatch");

	// table holds when no request is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(pend_q))
		else $error("table changed without a request");

endmodule

// ===== rtl/sbrt_out.sv =====
// ----------------------------------------------------------------------------
// sbrt_out
// result register with valid/stall handshake
// ----------------------------------------------------------------------------
module sbrt_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  sbrt_pkg::sbrt_result_t         result,
	output logic                           busy,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output sbrt_pkg::sbrt_result_t         rsp
);
	import sbrt_pkg::*;

	logic         valid_q;
	sbrt_result_t rsp_q;

	// full register that is not drained blocks the next request
	assign busy      = valid_q && rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

endmodule

// ===== rtl/split_bus_request_table_core.sv =====
// ----------------------------------------------------------------------------
// split_bus_request_table_core
// table of outstanding split bus transactions with aging and retirement
// ----------------------------------------------------------------------------
// A send or tick is accepted at any clock edge where req_valid is high and
// req_stall is low; its result appears in the result register on the next
// cycle. One request per cycle is sustained; req_stall rises only while a
// result sits in the result register and the consumer stalls it. Allocation
// of the lowest free slot, the aging pass and selection of the first expired
// slot are one priority-encoder pass over the slot flops, so the slot count
// sets the depth of that logic. The user must write bus_delay only while idle,
// through bus_delay_we / bus_delay_wdata; the block does not enforce this.
module split_bus_request_table_core #(
	parameter int TABLE_SLOTS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// bus delay register
	input  logic                            bus_delay_we,
	input  logic [sbrt_pkg::DELAY_W-1:0]    bus_delay_wdata,
	// request channel
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            op,
	input  logic [sbrt_pkg::CORE_W-1:0]     core,
	input  logic [sbrt_pkg::KIND_W-1:0]     req_kind,
	input  logic [sbrt_pkg::ADDR_W-1:0]     address,
	// result channel
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic                            accepted,
	output logic                            completed,
	output logic [sbrt_pkg::CORE_W-1:0]     done_core,
	output logic [sbrt_pkg::KIND_W-1:0]     done_kind,
	output logic [sbrt_pkg::ADDR_W-1:0]     done_address
);
	import sbrt_pkg::*;

	logic [DELAY_W-1:0] bus_delay_q;
	logic               fire;
	logic               busy;
	sbrt_item_t         item;
	sbrt_result_t       result;
	sbrt_result_t       rsp;

	// configuration register; the user must write it only while idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_delay_q <= BUS_DELAY_RST;
		end else if (bus_delay_we) begin
			bus_delay_q <= bus_delay_wdata;
		end
	end

	// request accepted when the result register can take its result
	assign req_stall = busy;
	assign fire      = req_valid && !busy;

	assign item.op      = op;
	assign item.core    = core;
	assign item.kind    = req_kind;
	assign item.address = address;

	// slot table with single-pass alloc / age / retire
	sbrt_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item),
		.bus_delay (bus_delay_q),
		.result    (result)
	);

	// registered result toward the consumer
	sbrt_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.result    (result),
		.busy      (busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign accepted     = rsp.accepted;
	assign completed    = rsp.completed;
	assign done_core    = rsp.core;
	assign done_kind    = rsp.kind;
	assign done_address = rsp.address;

endmodule
